// ===== rtl/mst_pkg.sv =====
// Shared types and codes for the multi-slot alarm timer.
package mst_pkg;

  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_ALLOC      = 4'd1,
    OP_FREE       = 4'd2,
    OP_START_ONCE = 4'd3,
    OP_START_PER  = 4'd4,
    OP_STOP       = 4'd5,
    OP_RESTART    = 4'd6,
    OP_INFO       = 4'd7,
    OP_NEXT       = 4'd8,
    OP_TIME       = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INVAL_STATE = 2'd1;
  localparam logic [1:0] ST_INVAL_ARG   = 2'd2;
  localparam logic [1:0] ST_NO_FREE     = 2'd3;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_ONCE = 2'd1;
  localparam logic [1:0] MODE_PER  = 2'd2;

  // Fire results reported per tick at most.
  localparam logic [3:0] MAX_OUT = 4'd8;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic        fired;
    logic        active;
    logic [63:0] period_out;
    logic [63:0] alarm_time;
    logic [31:0] fire_total;
    logic [63:0] now_time;
  } res_t;

endpackage

// ===== rtl/multi_slot_alarm_timer.sv =====
// Alarm timer bank: slot bookkeeping, shared add/compare unit and scan sequencer.
// Free, stop, start, restart, time and rejected ops go from idle to the push state;
// info reads the slot first; allocate walks the slots to the first free one.
// Tick and next-alarm scan the slots in turn (read, evaluate) through one shared
// 64-bit adder and comparator; a tick scan can stall while the output is full.
// One request at a time; a new one is taken while the last result waits.
// Sync reset zeroes the count and frees every slot; slot memories are cleared on allocate.
module multi_slot_alarm_timer #(
  parameter int NUM_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // slot[2:0], duration[66:3], zero pad
  input  logic [3:0]   s_axis_tuser,   // op[3:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [231:0] m_axis_tdata,   // status[1:0], slot_index[4:2], active[5],
                                       // period_out[69:6], alarm_time[133:70],
                                       // fire_total[165:134], now_time[229:166], pad
  output logic [0:0]   m_axis_tuser,   // fired[0]
  output logic         m_axis_tlast
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_EV    = 6'b000100,
    S_ALLOC = 6'b001000,
    S_INFO  = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state;

  // Count and per-slot control bits (reset-cleared).
  logic [63:0]   now;
  logic          alloc [NUM_SLOTS];
  logic [1:0]    mode  [NUM_SLOTS];

  // Slot payload memories with registered reads.
  logic [63:0]   period_mem [NUM_SLOTS];
  logic [63:0]   alarm_mem  [NUM_SLOTS];
  logic [31:0]   fires_mem  [NUM_SLOTS];
  logic [63:0]   period_q;
  logic [63:0]   alarm_q;
  logic [31:0]   fires_q;

  // Sequencer registers.
  logic [SW-1:0]    idx;
  mst_pkg::op_t     op_q;
  logic [3:0]       n_fire;
  logic             found;
  mst_pkg::res_t    pend;
  logic             pend_valid;
  mst_pkg::res_t    out;
  logic             out_valid;
  logic             out_last;

  // Request decode.
  mst_pkg::op_t  in_op;
  logic [2:0]    in_slot;
  logic [63:0]   in_dur;
  logic [6:0]    s_ext;
  logic [SW-1:0] s_idx;
  logic          s_valid;
  logic          accept;
  logic          is_start;
  logic [1:0]    eff_mode;
  logic [1:0]    start_status;
  logic          start_go;

  // Shared arithmetic unit.
  logic [63:0]   add_b;
  logic [63:0]   sum;
  logic [63:0]   cmp_a;
  logic [63:0]   cmp_b;
  logic          lt;

  // Scan evaluation.
  logic          ev_run;
  logic          ev_per;
  logic          due;
  logic          report;
  logic          out_free;
  logic          out_load;
  logic          stall;
  logic          fire_go;
  logic          alloc_go;
  logic          idx_last;
  logic [31:0]   fires_inc;
  logic [2:0]    idx3;
  mst_pkg::res_t fire_res;
  mst_pkg::res_t info_res;
  mst_pkg::res_t idle_res;
  mst_pkg::res_t base_res;
  mst_pkg::res_t alloc_res;

  // Memory write port.
  logic [SW-1:0] wr_idx;
  logic [SW-1:0] rd_idx;
  logic          we_period;
  logic          we_alarm;
  logic          we_fires;
  logic [63:0]   wr_period;
  logic [63:0]   wr_alarm;
  logic [31:0]   wr_fires;

  assign in_op   = mst_pkg::op_t'(s_axis_tuser);
  assign in_slot = s_axis_tdata[2:0];
  assign in_dur  = s_axis_tdata[66:3];
  assign s_ext   = 7'(in_slot);
  assign s_idx   = s_ext[SW-1:0];
  assign s_valid = (s_ext < 7'(NUM_SLOTS)) && alloc[s_idx];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_start = (in_op == mst_pkg::OP_START_ONCE) || (in_op == mst_pkg::OP_START_PER) ||
                    (in_op == mst_pkg::OP_RESTART);
  // Restart stops the slot first, so it never sees a running slot.
  assign eff_mode = (in_op == mst_pkg::OP_RESTART) ? mst_pkg::MODE_STOP : mode[s_idx];
  always_comb begin
    if (((in_op == mst_pkg::OP_START_PER) && (in_dur == 64'd0)) || !s_valid) begin
      start_status = mst_pkg::ST_INVAL_ARG;
    end else if (eff_mode != mst_pkg::MODE_STOP) begin
      start_status = mst_pkg::ST_INVAL_STATE;
    end else begin
      start_status = mst_pkg::ST_OK;
    end
  end
  assign start_go = accept && is_start && (start_status == mst_pkg::ST_OK);

  // Shared adder: now + 1 on tick, now + duration on start, now + period on rearm.
  always_comb begin
    if (state == S_EV) begin
      add_b = period_q;
    end else if (in_op == mst_pkg::OP_TICK) begin
      add_b = 64'd1;
    end else begin
      add_b = in_dur;
    end
  end
  assign sum = now + add_b;

  // Shared comparator: due test on tick, running minimum on next-alarm.
  always_comb begin
    if (op_q == mst_pkg::OP_TICK) begin
      cmp_a = now;
      cmp_b = alarm_q;
    end else begin
      cmp_a = alarm_q;
      cmp_b = pend.alarm_time;
    end
  end
  assign lt = cmp_a < cmp_b;

  assign ev_run    = alloc[idx] && (mode[idx] != mst_pkg::MODE_STOP);
  assign ev_per    = (mode[idx] == mst_pkg::MODE_PER);
  assign due       = ev_run && !lt;
  assign report    = n_fire < mst_pkg::MAX_OUT;
  assign out_free  = !out_valid || m_axis_tready;
  assign stall     = (op_q == mst_pkg::OP_TICK) && due && report && pend_valid && !out_free;
  assign fire_go   = (state == S_EV) && (op_q == mst_pkg::OP_TICK) && due && !stall;
  assign alloc_go  = (state == S_ALLOC) && !alloc[idx];
  assign idx_last  = (idx == SW'(NUM_SLOTS - 1));
  assign fires_inc = fires_q + 32'd1;
  assign idx3      = 3'(idx);
  // Hand a held fire on mid-scan, or the final result from the push state.
  assign out_load  = (fire_go && report && pend_valid) ||
                     ((state == S_PUSH) && pend_valid && out_free);

  always_comb begin
    fire_res            = '0;
    fire_res.status     = mst_pkg::ST_OK;
    fire_res.slot_index = idx3;
    fire_res.fired      = 1'b1;
    fire_res.active     = ev_per;
    fire_res.period_out = ev_per ? period_q : 64'd0;
    fire_res.alarm_time = ev_per ? sum : 64'd0;
    fire_res.fire_total = fires_inc;
    fire_res.now_time   = now;
  end

  always_comb begin
    info_res            = '0;
    info_res.status     = mst_pkg::ST_OK;
    info_res.slot_index = idx3;
    info_res.active     = ev_run;
    info_res.period_out = ev_per ? period_q : 64'd0;
    info_res.alarm_time = ev_run ? alarm_q : 64'd0;
    info_res.fire_total = fires_q;
    info_res.now_time   = now;
  end

  // Empty result stamped with the count; allocate reports the slot it lands on.
  always_comb begin
    base_res          = '0;
    base_res.now_time = now;
    alloc_res         = base_res;
    if (alloc[idx]) begin
      alloc_res.status = mst_pkg::ST_NO_FREE;
    end else begin
      alloc_res.status     = mst_pkg::ST_OK;
      alloc_res.slot_index = idx3;
    end
  end

  // Single-result ops settled in the request cycle.
  always_comb begin
    idle_res          = '0;
    idle_res.now_time = now;
    case (in_op)
      mst_pkg::OP_FREE, mst_pkg::OP_STOP, mst_pkg::OP_INFO: begin
        idle_res.status     = s_valid ? mst_pkg::ST_OK : mst_pkg::ST_INVAL_ARG;
        idle_res.slot_index = in_slot;
      end
      mst_pkg::OP_START_ONCE, mst_pkg::OP_START_PER, mst_pkg::OP_RESTART: begin
        idle_res.status     = start_status;
        idle_res.slot_index = in_slot;
      end
      mst_pkg::OP_TIME: begin
        idle_res.status = mst_pkg::ST_OK;
      end
      default: begin
        idle_res.status = mst_pkg::ST_INVAL_ARG;
      end
    endcase
  end

  // Memory port selection.
  assign rd_idx    = (state == S_IDLE) ? s_idx : idx;
  assign wr_idx    = (state == S_IDLE) ? s_idx : idx;
  assign we_period = start_go || alloc_go;
  assign we_alarm  = start_go || alloc_go || (fire_go && ev_per);
  assign we_fires  = alloc_go || fire_go;
  assign wr_period = alloc_go ? 64'd0 : in_dur;
  assign wr_alarm  = alloc_go ? 64'd0 : sum;
  assign wr_fires  = alloc_go ? 32'd0 : fires_inc;

  always_ff @(posedge clk) begin
    if (we_period) begin
      period_mem[wr_idx] <= wr_period;
    end
    if (we_alarm) begin
      alarm_mem[wr_idx] <= wr_alarm;
    end
    if (we_fires) begin
      fires_mem[wr_idx] <= wr_fires;
    end
    period_q <= period_mem[rd_idx];
    alarm_q  <= alarm_mem[rd_idx];
    fires_q  <= fires_mem[rd_idx];
  end

  // Output stage: load a handed-on result, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else if (out_load) begin
      out       <= pend;
      out_last  <= (state == S_PUSH);
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer, slot control bits and result staging.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      now        <= 64'd0;
      idx        <= '0;
      op_q       <= mst_pkg::OP_TICK;
      n_fire     <= 4'd0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        alloc[i] <= 1'b0;
        mode[i]  <= mst_pkg::MODE_STOP;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q <= in_op;
            case (in_op)
              mst_pkg::OP_TICK: begin
                now        <= sum;
                idx        <= '0;
                n_fire     <= 4'd0;
                pend_valid <= 1'b0;
                state      <= S_RD;
              end
              mst_pkg::OP_NEXT: begin
                idx        <= '0;
                found      <= 1'b0;
                pend       <= base_res;
                pend_valid <= 1'b0;
                state      <= S_RD;
              end
              mst_pkg::OP_ALLOC: begin
                idx   <= '0;
                state <= S_ALLOC;
              end
              mst_pkg::OP_INFO: begin
                idx <= s_idx;
                if (s_valid) begin
                  state <= S_INFO;
                end else begin
                  pend       <= idle_res;
                  pend_valid <= 1'b1;
                  state      <= S_PUSH;
                end
              end
              default: begin
                if (s_valid && ((in_op == mst_pkg::OP_FREE) || (in_op == mst_pkg::OP_STOP))) begin
                  mode[s_idx] <= mst_pkg::MODE_STOP;
                  if (in_op == mst_pkg::OP_FREE) begin
                    alloc[s_idx] <= 1'b0;
                  end
                end
                if (start_go) begin
                  mode[s_idx] <= (in_op == mst_pkg::OP_START_PER) ? mst_pkg::MODE_PER
                                                                  : mst_pkg::MODE_ONCE;
                end
                pend       <= idle_res;
                pend_valid <= 1'b1;
                state      <= S_PUSH;
              end
            endcase
          end
        end

        S_RD: begin
          state <= S_EV;
        end

        S_EV: begin
          if (!stall) begin
            if (op_q == mst_pkg::OP_TICK) begin
              if (due) begin
                if (!ev_per) begin
                  mode[idx] <= mst_pkg::MODE_STOP;
                end
                if (report) begin
                  // The held fire moves to the output; the new one waits for its
                  // successor or the end of the scan.
                  pend       <= fire_res;
                  pend_valid <= 1'b1;
                  n_fire     <= n_fire + 4'd1;
                end
              end
            end else if (ev_run && (!found || lt)) begin
              pend.alarm_time <= alarm_q;
              found           <= 1'b1;
            end
            if (idx_last) begin
              if (op_q != mst_pkg::OP_TICK) begin
                pend_valid <= 1'b1;
              end
              state <= S_PUSH;
            end else begin
              idx   <= idx + SW'(1);
              state <= S_RD;
            end
          end
        end

        S_ALLOC: begin
          if (!alloc[idx]) begin
            alloc[idx] <= 1'b1;
            mode[idx]  <= mst_pkg::MODE_STOP;
          end
          if (!alloc[idx] || idx_last) begin
            pend       <= alloc_res;
            pend_valid <= 1'b1;
            state      <= S_PUSH;
          end else begin
            idx <= idx + SW'(1);
          end
        end

        S_INFO: begin
          pend       <= info_res;
          pend_valid <= 1'b1;
          state      <= S_PUSH;
        end

        S_PUSH: begin
          // Hold the final result until the output stage frees up.
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out.fired;
  assign m_axis_tdata  = {2'b00, out.now_time, out.fire_total, out.alarm_time,
                          out.period_out, out.active, out.slot_index, out.status};

endmodule

// ===== bench/tb_multi_slot_alarm_timer.sv =====
// Self-checking stream testbench for the multi-slot alarm timer bank.
`timescale 1ns / 100ps

module tb_multi_slot_alarm_timer;

  localparam int NUM_SLOTS = 8;
  localparam int N_RANDOM  = 104;
  // Drain allowance: one full scan of the bank plus margin.
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 12;

  // Op codes outside the defined set; the block must reject them.
  localparam logic [3:0] OP_UNDEF_LOW = 4'd10;
  localparam logic [3:0] OP_UNDEF_TOP = 4'd15;
  localparam logic [63:0] DUR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // One expected result, laid out field by field.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic        fired;
    logic        active;
    logic [63:0] period_out;
    logic [63:0] alarm_time;
    logic [31:0] fire_total;
    logic [63:0] now_time;
    logic        last;
  } timer_res_t;

  // Directed row: request plus, where obvious, the typed status and slot.
  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  slot;
    logic [63:0] dur;
    logic        typed;
    logic [1:0]  status;
    logic [2:0]  slot_index;
  } dir_row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;   // slot[2:0], duration[66:3], zero pad
  logic [3:0]   s_axis_tuser;   // op[3:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [231:0] m_axis_tdata;   // status[1:0], slot_index[4:2], active[5],
                                // period_out[69:6], alarm_time[133:70],
                                // fire_total[165:134], now_time[229:166], pad
  logic [0:0]   m_axis_tuser;   // fired[0]
  logic         m_axis_tlast;

  multi_slot_alarm_timer #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Shadow copy of the bank, advanced once per accepted request.
  logic [63:0] now_shadow;
  logic        alloc_shadow  [NUM_SLOTS];
  logic [1:0]  mode_shadow   [NUM_SLOTS];
  logic [63:0] period_shadow [NUM_SLOTS];
  logic [63:0] alarm_shadow  [NUM_SLOTS];
  logic [31:0] fires_shadow  [NUM_SLOTS];

  // Results still owed by the block, oldest first.
  timer_res_t pending_results[$];
  dir_row_t   dir_rows[$];

  int err_cnt;
  int n_reqs;
  int n_results;
  int n_fires;
  int src_idle_pct;
  int snk_stall_pct;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case the block hangs or loses a result.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Queue one result stamped with the current shadow count.
  function automatic void push_result(logic [1:0] st, logic [2:0] idx, logic fired,
                                      logic act, logic [63:0] per, logic [63:0] alarm,
                                      logic [31:0] fires, logic last);
    timer_res_t r;
    r.status     = st;
    r.slot_index = idx;
    r.fired      = fired;
    r.active     = act;
    r.period_out = per;
    r.alarm_time = alarm;
    r.fire_total = fires;
    r.now_time   = now_shadow;
    r.last       = last;
    pending_results = {pending_results, r};
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(logic [3:0] op, logic [2:0] sl, logic [63:0] dur,
                                  logic typed, logic [1:0] st, logic [2:0] idx);
    dir_row_t row;
    row.op         = op;
    row.slot       = sl;
    row.dur        = dur;
    row.typed      = typed;
    row.status     = st;
    row.slot_index = idx;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic logic slot_live(logic [2:0] sl);
    return (int'(sl) < NUM_SLOTS) && alloc_shadow[sl];
  endfunction

  // Advance the shadow bank by one request and queue what it should produce.
  function automatic void predict_request(logic [3:0] op, logic [2:0] sl,
                                          logic [63:0] dur);
    int         i;
    int         n;
    logic       any;
    logic       per;
    logic [63:0] best;
    timer_res_t tail;
    n    = 0;
    any  = 1'b0;
    best = '0;
    case (op)
      mst_pkg::OP_TICK: begin
        now_shadow = now_shadow + 64'd1;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (alloc_shadow[i] && mode_shadow[i] != mst_pkg::MODE_STOP &&
              alarm_shadow[i] <= now_shadow) begin
            fires_shadow[i] = fires_shadow[i] + 32'd1;
            if (mode_shadow[i] == mst_pkg::MODE_PER)
              alarm_shadow[i] = now_shadow + period_shadow[i];
            else
              mode_shadow[i] = mst_pkg::MODE_STOP;
            // Service every due slot, but report only the first MAX_OUT.
            if (n < int'(mst_pkg::MAX_OUT)) begin
              per = (mode_shadow[i] == mst_pkg::MODE_PER);
              push_result(mst_pkg::ST_OK, 3'(i), 1'b1, per, per ? period_shadow[i] : '0,
                          per ? alarm_shadow[i] : '0, fires_shadow[i], 1'b0);
              n++;
            end
          end
        end
        // Quiet tick leaves nothing; otherwise flag the final fire.
        if (n > 0) begin
          tail = pending_results[pending_results.size() - 1];
          tail.last = 1'b1;
          pending_results[pending_results.size() - 1] = tail;
        end
      end
      mst_pkg::OP_ALLOC: begin
        for (i = 0; i < NUM_SLOTS && !any; i++) begin
          if (!alloc_shadow[i]) begin
            alloc_shadow[i]  = 1'b1;
            mode_shadow[i]   = mst_pkg::MODE_STOP;
            period_shadow[i] = '0;
            alarm_shadow[i]  = '0;
            fires_shadow[i]  = '0;
            any = 1'b1;
            push_result(mst_pkg::ST_OK, 3'(i), 1'b0, 1'b0, '0, '0, '0, 1'b1);
          end
        end
        if (!any)
          push_result(mst_pkg::ST_NO_FREE, 3'd0, 1'b0, 1'b0, '0, '0, '0, 1'b1);
      end
      mst_pkg::OP_FREE: begin
        if (!slot_live(sl)) begin
          push_result(mst_pkg::ST_INVAL_ARG, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          alloc_shadow[sl] = 1'b0;
          mode_shadow[sl]  = mst_pkg::MODE_STOP;
          push_result(mst_pkg::ST_OK, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end
      end
      mst_pkg::OP_START_ONCE, mst_pkg::OP_START_PER, mst_pkg::OP_RESTART: begin
        // Zero period is rejected before the slot is even looked at.
        if (op == mst_pkg::OP_START_PER && dur == '0) begin
          push_result(mst_pkg::ST_INVAL_ARG, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else if (!slot_live(sl)) begin
          push_result(mst_pkg::ST_INVAL_ARG, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          if (op == mst_pkg::OP_RESTART)
            mode_shadow[sl] = mst_pkg::MODE_STOP;
          if (mode_shadow[sl] != mst_pkg::MODE_STOP) begin
            push_result(mst_pkg::ST_INVAL_STATE, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            mode_shadow[sl]   = (op == mst_pkg::OP_START_PER) ? mst_pkg::MODE_PER
                                                              : mst_pkg::MODE_ONCE;
            period_shadow[sl] = dur;
            alarm_shadow[sl]  = now_shadow + dur;
            push_result(mst_pkg::ST_OK, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
          end
        end
      end
      mst_pkg::OP_STOP: begin
        if (!slot_live(sl)) begin
          push_result(mst_pkg::ST_INVAL_ARG, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          mode_shadow[sl] = mst_pkg::MODE_STOP;
          push_result(mst_pkg::ST_OK, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end
      end
      mst_pkg::OP_INFO: begin
        if (!slot_live(sl)) begin
          push_result(mst_pkg::ST_INVAL_ARG, sl, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          any = (mode_shadow[sl] != mst_pkg::MODE_STOP);
          per = (mode_shadow[sl] == mst_pkg::MODE_PER);
          push_result(mst_pkg::ST_OK, sl, 1'b0, any, per ? period_shadow[sl] : '0,
                      any ? alarm_shadow[sl] : '0, fires_shadow[sl], 1'b1);
        end
      end
      mst_pkg::OP_NEXT: begin
        // Earliest alarm among running slots, zero when none runs.
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (alloc_shadow[i] && mode_shadow[i] != mst_pkg::MODE_STOP &&
              (!any || alarm_shadow[i] < best)) begin
            best = alarm_shadow[i];
            any  = 1'b1;
          end
        end
        push_result(mst_pkg::ST_OK, 3'd0, 1'b0, 1'b0, '0, any ? best : '0, '0, 1'b1);
      end
      mst_pkg::OP_TIME: push_result(mst_pkg::ST_OK, 3'd0, 1'b0, 1'b0, '0, '0, '0, 1'b1);
      default: push_result(mst_pkg::ST_INVAL_ARG, 3'd0, 1'b0, 1'b0, '0, '0, '0, 1'b1);
    endcase
  endfunction

  // Present one request at a falling edge, hold it until the block takes it,
  // then predict. Returns at the next falling edge with tvalid still high.
  task automatic send_req(input logic [3:0] op, input logic [2:0] sl,
                          input logic [63:0] dur, input logic typed,
                          input logic [1:0] typed_st, input logic [2:0] typed_idx);
    timer_res_t r;
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'd0, dur, sl};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(op, sl, dur);
    n_reqs++;
    // Typed rows: replace the prediction by the value read off by hand.
    if (typed) begin
      r = pending_results[pending_results.size() - 1];
      r.status     = typed_st;
      r.slot_index = typed_idx;
      r.fired      = 1'b0;
      r.active     = 1'b0;
      r.period_out = '0;
      r.alarm_time = '0;
      r.fire_total = '0;
      r.last       = 1'b1;
      pending_results[pending_results.size() - 1] = r;
    end
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v,
                                      logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Result side: stall at random, decided at the falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin
    timer_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: tdata %0h", m_axis_tdata);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        check_field("status",     64'(e.status),     64'(m_axis_tdata[1:0]));
        check_field("slot_index", 64'(e.slot_index), 64'(m_axis_tdata[4:2]));
        check_field("fired",      64'(e.fired),      64'(m_axis_tuser[0]));
        check_field("active",     64'(e.active),     64'(m_axis_tdata[5]));
        check_field("period_out", e.period_out,      m_axis_tdata[69:6]);
        check_field("alarm_time", e.alarm_time,      m_axis_tdata[133:70]);
        check_field("fire_total", 64'(e.fire_total), 64'(m_axis_tdata[165:134]));
        check_field("now_time",   e.now_time,        m_axis_tdata[229:166]);
        check_field("last",       64'(e.last),       64'(m_axis_tlast));
        n_results++;
        if (m_axis_tuser[0])
          n_fires++;
      end
    end
  end

  initial begin
    int          ph;
    int          k;
    int          pick;
    logic [3:0]  op;
    logic [2:0]  sl;
    logic [63:0] dur;
    dir_row_t    row;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = mst_pkg::OP_TICK;
    err_cnt       = 0;
    n_reqs        = 0;
    n_results     = 0;
    n_fires       = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    now_shadow    = '0;
    for (k = 0; k < NUM_SLOTS; k++) begin
      alloc_shadow[k]  = 1'b0;
      mode_shadow[k]   = mst_pkg::MODE_STOP;
      period_shadow[k] = '0;
      alarm_shadow[k]  = '0;
      fires_shadow[k]  = '0;
    end

    // Queries and rejects straight out of reset.
    add_row(mst_pkg::OP_TIME,       3'd0, 64'd0,   1'b1, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_NEXT,       3'd0, 64'd0,   1'b1, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_INFO,       3'd0, 64'd0,   1'b1, mst_pkg::ST_INVAL_ARG,   3'd0);
    add_row(mst_pkg::OP_FREE,       3'd7, 64'd0,   1'b1, mst_pkg::ST_INVAL_ARG,   3'd7);
    add_row(mst_pkg::OP_START_PER,  3'd0, 64'd0,   1'b1, mst_pkg::ST_INVAL_ARG,   3'd0);
    add_row(OP_UNDEF_TOP,           3'd5, DUR_MAX, 1'b1, mst_pkg::ST_INVAL_ARG,   3'd0);
    // Fill the bank, overflow it, then free and reclaim the top slot.
    for (k = 0; k < NUM_SLOTS; k++)
      add_row(mst_pkg::OP_ALLOC,    3'(k), 64'd0,  1'b1, mst_pkg::ST_OK,          3'(k));
    add_row(mst_pkg::OP_ALLOC,      3'd0, 64'd0,   1'b1, mst_pkg::ST_NO_FREE,     3'd0);
    add_row(mst_pkg::OP_FREE,       3'd7, 64'd0,   1'b1, mst_pkg::ST_OK,          3'd7);
    add_row(mst_pkg::OP_ALLOC,      3'd0, 64'd0,   1'b1, mst_pkg::ST_OK,          3'd7);
    // Starts: running slot refused, max duration wraps, zero one-shot is due.
    add_row(mst_pkg::OP_START_ONCE, 3'd0, 64'd2,   1'b1, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_START_ONCE, 3'd0, 64'd5,   1'b1, mst_pkg::ST_INVAL_STATE, 3'd0);
    add_row(mst_pkg::OP_START_PER,  3'd1, 64'd1,   1'b1, mst_pkg::ST_OK,          3'd1);
    add_row(mst_pkg::OP_START_PER,  3'd2, DUR_MAX, 1'b1, mst_pkg::ST_OK,          3'd2);
    add_row(mst_pkg::OP_START_ONCE, 3'd3, 64'd0,   1'b1, mst_pkg::ST_OK,          3'd3);
    add_row(mst_pkg::OP_NEXT,       3'd0, 64'd0,   1'b0, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_TICK,       3'd0, 64'd0,   1'b0, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_RESTART,    3'd0, 64'd1,   1'b1, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_STOP,       3'd4, 64'd0,   1'b1, mst_pkg::ST_OK,          3'd4);
    add_row(mst_pkg::OP_TICK,       3'd0, 64'd0,   1'b0, mst_pkg::ST_OK,          3'd0);
    add_row(mst_pkg::OP_INFO,       3'd1, 64'd0,   1'b0, mst_pkg::ST_OK,          3'd0);

    // Hold reset, release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table with no idling on either side.
    for (k = 0; k < dir_rows.size(); k++) begin
      row = dir_rows[k];
      send_req(row.op, row.slot, row.dur, row.typed, row.status, row.slot_index);
    end

    // Random requests in four idling phases: none, sender, receiver, both.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      for (k = 0; k < N_RANDOM / 4; k++) begin
        // Favor ticks and starts so that slots keep firing and rearming.
        pick = $urandom_range(99);
        if (pick < 35)      op = mst_pkg::OP_TICK;
        else if (pick < 42) op = mst_pkg::OP_ALLOC;
        else if (pick < 47) op = mst_pkg::OP_FREE;
        else if (pick < 60) op = mst_pkg::OP_START_ONCE;
        else if (pick < 70) op = mst_pkg::OP_START_PER;
        else if (pick < 75) op = mst_pkg::OP_STOP;
        else if (pick < 82) op = mst_pkg::OP_RESTART;
        else if (pick < 89) op = mst_pkg::OP_INFO;
        else if (pick < 94) op = mst_pkg::OP_NEXT;
        else if (pick < 97) op = mst_pkg::OP_TIME;
        else                op = 4'($urandom_range(OP_UNDEF_TOP, OP_UNDEF_LOW));
        sl = 3'($urandom_range(NUM_SLOTS - 1));
        // Mostly short durations; some full-width and near-wrap values.
        case ($urandom_range(9))
          6:       dur = {$urandom, $urandom};
          7:       dur = DUR_MAX - 64'($urandom_range(3));
          8:       dur = 64'($urandom_range(20, 1));
          default: dur = 64'($urandom_range(6));
        endcase
        send_req(op, sl, dur, 1'b0, mst_pkg::ST_OK, 3'd0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for a trailing scan that might still emit.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests (directed table plus four idling phases).", n_reqs);
    $display("Checked %0d results, %0d of them alarm fires.", n_results, n_fires);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
